@@ rtl/ordered_list_engine_defines.svh @@
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// types and constants of the ordered list engine
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int OLE_CAPACITY = 64;

	typedef enum logic [2:0] {
		K_INS_FRONT  = 3'd0,
		K_INS_BACK   = 3'd1,
		K_INS_BEFORE = 3'd2,
		K_DEL_VALUE  = 3'd3,
		K_DEL_FRONT  = 3'd4,
		K_DEL_BACK   = 3'd5,
		K_CLEAR      = 3'd6,
		K_NOP        = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_RD_HEAD,
		CMD_WALK,
		CMD_GRAB,
		CMD_BACK_FOUND,
		CMD_UNLINK,
		CMD_GIVE,
		CMD_RD_FREE,
		CMD_TAKE,
		CMD_FIX,
		CMD_CLEAR,
		CMD_RD_FRONT,
		CMD_CAP_FRONT,
		CMD_CAP_BACK
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH,
		S_BWALK,
		S_GRAB,
		S_UNLINK,
		S_GIVE,
		S_RDFREE,
		S_TAKE,
		S_FIX,
		S_FIN1,
		S_FIN2,
		S_FIN3,
		S_DONE
	} state_t;

	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  empty;
		logic  head_is_tail;
		logic  hit;
		logic  link_nil;
		logic  link_is_tail;
	} dp_stat_t;

endpackage

@@ rtl/ole_dp.sv @@
// ----------------------------------------------------------------------------
// ole_dp
// node pool memories, list pointers, walk registers and result registers
// ----------------------------------------------------------------------------
module ole_dp #(
	parameter int CAPACITY = ole_pkg::OLE_CAPACITY,
	parameter int IW = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ole_pkg::cmd_t          cmd,
	input  logic [2:0]             kind,
	input  logic signed [31:0]     value,
	input  logic signed [31:0]     target,
	output ole_pkg::dp_stat_t      stat,
	output logic signed [31:0]     front_value,
	output logic signed [31:0]     back_value,
	output logic [IW-1:0]          count
);
	import ole_pkg::*;

	localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam logic [IW-1:0] NIL = IW'(CAPACITY);

	logic [31:0]   val_mem  [CAPACITY];
	logic [IW-1:0] link_mem [CAPACITY];

	kind_t              kind_q;
	logic signed [31:0] value_q, target_q;
	logic [IW-1:0]      head_q, tail_q, free_q, fresh_q, count_q;
	logic [IW-1:0]      cur_q, prev_q, nx_q, n_q, raddr_q;
	logic [31:0]        vdata_q;
	logic [IW-1:0]      lrd_q;
	logic signed [31:0] front_q, back_q;

	logic [IW-1:0] ldata, ra, lw_addr, lw_data, newlink;
	logic          lw_en;
	logic [31:0]   key;

	// nodes at or above the fresh mark are free and implicitly chained to i+1
	assign ldata = (raddr_q >= fresh_q) ? IW'(raddr_q + 1'b1) : lrd_q;
	assign key   = (kind_q == K_INS_BEFORE) ? target_q : value_q;

	assign stat.kind         = kind_q;
	assign stat.full         = (count_q == NIL);
	assign stat.empty        = (head_q == NIL);
	assign stat.head_is_tail = (head_q == tail_q);
	assign stat.hit          = (vdata_q == key);
	assign stat.link_nil     = (ldata == NIL);
	assign stat.link_is_tail = (ldata == tail_q);

	always_comb begin
		case (kind_q)
			K_INS_FRONT:  newlink = head_q;
			K_INS_BEFORE: newlink = cur_q;
			default:      newlink = NIL;
		endcase
	end

	always_comb begin
		case (cmd)
			CMD_RD_HEAD, CMD_RD_FRONT: ra = head_q;
			CMD_WALK:                  ra = ldata;
			CMD_RD_FREE:               ra = free_q;
			CMD_CAP_FRONT:             ra = tail_q;
			default:                   ra = raddr_q;
		endcase
	end

	always_comb begin
		lw_en   = 1'b0;
		lw_addr = free_q;
		lw_data = NIL;
		case (cmd)
			CMD_TAKE: begin
				lw_en   = 1'b1;
				lw_data = newlink;
			end
			CMD_FIX: begin
				lw_en   = (prev_q != NIL);
				lw_addr = prev_q;
				lw_data = n_q;
			end
			CMD_UNLINK: begin
				lw_en   = (prev_q != NIL);
				lw_addr = prev_q;
				lw_data = nx_q;
			end
			CMD_GIVE: begin
				lw_en   = 1'b1;
				lw_addr = cur_q;
				lw_data = free_q;
			end
			default: begin
				lw_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			link_mem[lw_addr[AW-1:0]] <= lw_data;
		end
		if (cmd == CMD_TAKE) begin
			val_mem[free_q[AW-1:0]] <= value_q;
		end
		vdata_q <= val_mem[ra[AW-1:0]];
		lrd_q   <= link_mem[ra[AW-1:0]];
		raddr_q <= ra;
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LATCH: begin
				kind_q   <= kind_t'(kind);
				value_q  <= value;
				target_q <= target;
			end
			CMD_RD_HEAD: begin
				cur_q  <= head_q;
				prev_q <= NIL;
			end
			CMD_WALK: begin
				prev_q <= cur_q;
				cur_q  <= ldata;
			end
			CMD_GRAB: begin
				nx_q <= ldata;
			end
			CMD_BACK_FOUND: begin
				prev_q <= cur_q;
				cur_q  <= tail_q;
				nx_q   <= NIL;
			end
			CMD_TAKE: begin
				n_q <= free_q;
				if (kind_q == K_INS_FRONT) begin
					prev_q <= NIL;
				end else if (kind_q == K_INS_BACK) begin
					prev_q <= tail_q;
				end
			end
			CMD_CAP_FRONT: begin
				front_q <= (head_q == NIL) ? -32'sd1 : $signed(vdata_q);
			end
			CMD_CAP_BACK: begin
				back_q <= (tail_q == NIL) ? -32'sd1 : $signed(vdata_q);
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			tail_q  <= NIL;
			free_q  <= '0;
			fresh_q <= '0;
			count_q <= '0;
		end else begin
			case (cmd)
				CMD_TAKE: begin
					count_q <= IW'(count_q + 1'b1);
					if (free_q >= fresh_q) begin
						free_q  <= IW'(free_q + 1'b1);
						fresh_q <= IW'(fresh_q + 1'b1);
					end else begin
						free_q <= ldata;
					end
					case (kind_q)
						K_INS_FRONT: begin
							head_q <= free_q;
							if (tail_q == NIL) begin
								tail_q <= free_q;
							end
						end
						K_INS_BACK: begin
							if (tail_q == NIL) begin
								head_q <= free_q;
							end
							tail_q <= free_q;
						end
						default: begin
							if (prev_q == NIL) begin
								head_q <= free_q;
							end
						end
					endcase
				end
				CMD_UNLINK: begin
					if (prev_q == NIL) begin
						head_q <= nx_q;
					end
					if (tail_q == cur_q) begin
						tail_q <= prev_q;
					end
				end
				CMD_GIVE: begin
					free_q  <= cur_q;
					count_q <= IW'(count_q - 1'b1);
				end
				CMD_CLEAR: begin
					head_q  <= NIL;
					tail_q  <= NIL;
					free_q  <= '0;
					fresh_q <= '0;
					count_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	assign front_value = front_q;
	assign back_value  = back_q;
	assign count       = count_q;

endmodule

@@ rtl/ole_ctrl.sv @@
// ----------------------------------------------------------------------------
// ole_ctrl
// operation sequencer of the ordered list engine
// ----------------------------------------------------------------------------
module ole_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ole_pkg::dp_stat_t stat,
	output ole_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done,
	output logic [1:0]        status
);
	import ole_pkg::*;

	state_t  state_q, state_d;
	status_t status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd      = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd     = CMD_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				status_d = ST_OK;
				state_d  = S_FIN1;
				case (stat.kind)
					K_INS_FRONT, K_INS_BACK: begin
						if (stat.full) begin
							status_d = ST_FULL;
						end else begin
							cmd     = CMD_RD_FREE;
							state_d = S_TAKE;
						end
					end
					K_INS_BEFORE: begin
						if (stat.full) begin
							status_d = ST_FULL;
						end else if (stat.empty) begin
							status_d = ST_NOT_FOUND;
						end else begin
							cmd     = CMD_RD_HEAD;
							state_d = S_SRCH;
						end
					end
					K_DEL_VALUE: begin
						if (stat.empty) begin
							status_d = ST_EMPTY;
						end else begin
							cmd     = CMD_RD_HEAD;
							state_d = S_SRCH;
						end
					end
					K_DEL_FRONT: begin
						if (stat.empty) begin
							status_d = ST_EMPTY;
						end else begin
							cmd     = CMD_RD_HEAD;
							state_d = S_GRAB;
						end
					end
					K_DEL_BACK: begin
						if (stat.empty) begin
							status_d = ST_EMPTY;
						end else begin
							cmd     = CMD_RD_HEAD;
							state_d = stat.head_is_tail ? S_GRAB : S_BWALK;
						end
					end
					K_CLEAR: begin
						cmd = CMD_CLEAR;
					end
					default: begin
						state_d = S_FIN1;
					end
				endcase
			end
			S_SRCH: begin
				if (stat.hit) begin
					cmd     = CMD_GRAB;
					state_d = (stat.kind == K_INS_BEFORE) ? S_RDFREE : S_UNLINK;
				end else if (stat.link_nil) begin
					status_d = ST_NOT_FOUND;
					state_d  = S_FIN1;
				end else begin
					cmd = CMD_WALK;
				end
			end
			S_BWALK: begin
				if (stat.link_is_tail) begin
					cmd     = CMD_BACK_FOUND;
					state_d = S_UNLINK;
				end else begin
					cmd = CMD_WALK;
				end
			end
			S_GRAB: begin
				cmd     = CMD_GRAB;
				state_d = S_UNLINK;
			end
			S_UNLINK: begin
				cmd     = CMD_UNLINK;
				state_d = S_GIVE;
			end
			S_GIVE: begin
				cmd     = CMD_GIVE;
				state_d = S_FIN1;
			end
			S_RDFREE: begin
				cmd     = CMD_RD_FREE;
				state_d = S_TAKE;
			end
			S_TAKE: begin
				cmd     = CMD_TAKE;
				state_d = S_FIX;
			end
			S_FIX: begin
				cmd     = CMD_FIX;
				state_d = S_FIN1;
			end
			S_FIN1: begin
				cmd     = CMD_RD_FRONT;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				cmd     = CMD_CAP_FRONT;
				state_d = S_FIN3;
			end
			S_FIN3: begin
				cmd     = CMD_CAP_BACK;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_DONE);
	assign status = status_q;

endmodule

@@ rtl/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// bounded singly linked list of signed 32-bit values in a node pool
// ----------------------------------------------------------------------------
// One operation per item, one result per item. An item is taken when start is
// high and busy is low; its result appears for one cycle with done high and
// must be captured then. Busy stays high through the done cycle, so the next
// item can be taken in the cycle after done. An operation that needs no walk
// (insert at front or back, delete front, delete back of a one-node list,
// clear, refusals) never enters the search or back-walk state. Insert before a
// target, delete by value and delete back walk the list one node per cycle
// through the node memory read port. No clearing pass is needed after reset
// or clear.
module ordered_list_engine #(
	parameter int CAPACITY = ole_pkg::OLE_CAPACITY,
	parameter int IW = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value,
	input  logic signed [31:0] target,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [IW-1:0]      count
);
	import ole_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	ole_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	ole_dp #(
		.CAPACITY (CAPACITY),
		.IW       (IW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.value       (value),
		.target      (target),
		.stat        (stat),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count)
	);

endmodule

@@ rtl/ole_checker.sv @@
// ----------------------------------------------------------------------------
// ole_checker
// port-level checks of the ordered list engine
// ----------------------------------------------------------------------------
`include "ordered_list_engine_defines.svh"

module ole_checker #(
	parameter int CAPACITY = ole_pkg::OLE_CAPACITY,
	parameter int IW = $clog2(CAPACITY + 1)
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic signed [31:0] front_value,
	input logic signed [31:0] back_value,
	input logic [IW-1:0]      count
);
	import ole_pkg::*;

	`OLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted but not busy")
	`OLE_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe not single")
	`OLE_ASSERT_NOW(a_empty_count, done && status == ST_EMPTY, count == '0, "empty with nodes")
	`OLE_ASSERT_NOW(a_empty_ends, done && count == '0, (front_value & back_value) == -32'sd1, "ends")
	`OLE_ASSERT_NOW(a_count_cap, done, count <= IW'(CAPACITY), "count above capacity")

endmodule

bind ordered_list_engine ole_checker #(.CAPACITY(CAPACITY), .IW(IW)) u_ole_checker (.*);
